FILE: hw/rtl/sppu_pkg.sv
// Shared types and constants for the surplus production projection unit.
// No dependencies; used by sppu_arith and the top level.
package sppu_pkg;

  // Fixed-point layout
  localparam int unsigned BioW  = 49;  // signed Q32.16 biomass word
  localparam int unsigned RateW = 32;  // signed Q2.30 rate word
  localparam int unsigned InW   = 48;  // unsigned Q32.16 input word
  localparam int unsigned Frac  = 30;  // fraction bits of a rate

  // Operation of the shared serial unit
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } arith_op_e;

  // Request to the serial unit
  typedef struct packed {
    logic      start;
    arith_op_e op;
    logic      wide;   // saturate to BioW, else to RateW
  } arith_req_t;

  // Response from the serial unit
  typedef struct packed {
    logic done;
    logic div_zero;
  } arith_rsp_t;

endpackage

FILE: hw/rtl/surplus_production_projection_unit.sv
// Top level of the surplus production projection unit.
// Depends on sppu_pkg and sppu_arith.
//
// One request carries one catch year of a simulated stock. A first-year request
// is the shortest, and a later year takes longer with logistic effort than with
// linear effort; the time is set by the single shared bit-serial multiply/divide
// unit, which works through one product or quotient at a time. A first year needs
// one quotient, and every later year chains five to eight operations. The next
// request is taken as soon as the year is finished, even while a result still
// sits in the output register waiting to be taken. Configuration must be written
// only while idle; the unit itself does not enforce this.
module surplus_production_projection_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic                              cfg_data_i,
  // input requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              first_year_i,
  input  logic                              last_year_i,
  input  logic [sppu_pkg::InW-1:0]          catch_value_i,
  input  logic [sppu_pkg::InW-1:0]          capacity_i,
  input  logic signed [sppu_pkg::RateW-1:0] growth_rate_i,
  input  logic signed [sppu_pkg::RateW-1:0] effort_rate_i,
  input  logic signed [sppu_pkg::RateW-1:0] effort_shape_i,
  // result requests
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sppu_pkg::BioW-1:0]  final_biomass_o,
  output logic signed [sppu_pkg::RateW-1:0] final_exploitation_o,
  output logic                              survived_o
);
  import sppu_pkg::*;

  localparam int unsigned SumW = BioW + 2;
  localparam logic signed [SumW-1:0] OneRate = SumW'(1) <<< Frac;

  localparam logic CfgLogistic = 1'b0;
  localparam logic CfgObserved = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  typedef enum logic [3:0] {
    ST_FIRST, ST_AK, ST_RATIO, ST_FACT, ST_ELOG,
    ST_ELIN, ST_BK, ST_RB, ST_GROW, ST_PC
  } step_e;

  function automatic logic signed [RateW-1:0] sat_rate(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] mx, mn;
    mx = (SumW'(1) <<< (RateW - 1)) - SumW'(1);
    mn = ~mx;
    if (v > mx) return mx[RateW-1:0];
    if (v < mn) return mn[RateW-1:0];
    return v[RateW-1:0];
  endfunction

  function automatic logic signed [BioW-1:0] sat_bio(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] mx, mn;
    mx = (SumW'(1) <<< (BioW - 1)) - SumW'(1);
    mn = ~mx;
    if (v > mx) return mx[BioW-1:0];
    if (v < mn) return mn[BioW-1:0];
    return v[BioW-1:0];
  endfunction

  state_e state_q;
  step_e  step_q;

  logic cfg_logistic_q, cfg_observed_q;

  // stock state
  logic signed [BioW-1:0]  biomass_q, pred_catch_q;
  logic signed [RateW-1:0] expl_q, expl0_q;
  logic [InW-1:0]          prev_catch_q;
  logic                    alive_q;

  // year operands and intermediates
  logic [InW-1:0]          catch_q, cap_q;
  logic signed [RateW-1:0] r_q, x_q, a_q;
  logic                    last_q;
  logic signed [BioW-1:0]  tmp_q;
  logic signed [RateW-1:0] term_q, frac_q;

  // result register
  logic                    out_valid_q;
  logic signed [BioW-1:0]  out_bio_q;
  logic signed [RateW-1:0] out_expl_q;
  logic                    out_surv_q;

  arith_req_t             req;
  arith_rsp_t             rsp;
  logic signed [BioW-1:0] opa, opb, res;
  logic signed [BioW-1:0] sub_catch;
  logic                   in_acc, out_free, step_last;
  step_e                  step_nxt;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // operand selection per step
  always_comb begin
    req.start = (state_q == S_ISSUE);
    req.op    = OP_MUL;
    req.wide  = 1'b0;
    opa       = '0;
    opb       = '0;
    unique case (step_q)
      ST_FIRST: begin
        req.op = OP_DIV;
        opa = $signed({1'b0, catch_q});
        opb = $signed({1'b0, cap_q});
      end
      ST_AK: begin
        req.wide = 1'b1;
        opa = BioW'(a_q);
        opb = $signed({1'b0, cap_q});
      end
      ST_RATIO: begin
        req.op = OP_DIV;
        opa = biomass_q;
        opb = tmp_q;
      end
      ST_FACT: begin
        opa = BioW'(x_q);
        opb = BioW'(term_q);
      end
      ST_ELOG: begin
        opa = BioW'(expl_q);
        opb = BioW'(term_q);
      end
      ST_ELIN: begin
        opa = BioW'(x_q);
        opb = BioW'(expl0_q);
      end
      ST_BK: begin
        req.op = OP_DIV;
        opa = biomass_q;
        opb = $signed({1'b0, cap_q});
      end
      ST_RB: begin
        req.wide = 1'b1;
        opa = BioW'(r_q);
        opb = biomass_q;
      end
      ST_GROW: begin
        req.wide = 1'b1;
        opa = tmp_q;
        opb = BioW'(frac_q);
      end
      ST_PC: begin
        req.wide = 1'b1;
        opa = biomass_q;
        opb = BioW'(expl_q);
      end
      default: ;
    endcase
  end

  // step sequencing
  always_comb begin
    step_nxt  = step_q;
    step_last = 1'b0;
    unique case (step_q)
      ST_FIRST: step_last = 1'b1;
      ST_AK:    step_nxt  = ST_RATIO;
      ST_RATIO: step_nxt  = ST_FACT;
      ST_FACT:  step_nxt  = ST_ELOG;
      ST_ELOG:  step_nxt  = ST_BK;
      ST_ELIN:  step_nxt  = ST_BK;
      ST_BK:    step_nxt  = ST_RB;
      ST_RB:    step_nxt  = ST_GROW;
      ST_GROW:  step_nxt  = ST_PC;
      ST_PC:    step_last = 1'b1;
      default:  step_last = 1'b1;
    endcase
  end

  assign sub_catch = cfg_observed_q ? $signed({1'b0, prev_catch_q}) : pred_catch_q;

  sppu_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (rsp),
    .res_o  (res)
  );

  // sequencer, configuration and stock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      step_q         <= ST_FIRST;
      cfg_logistic_q <= 1'b1;
      cfg_observed_q <= 1'b1;
      biomass_q      <= '0;
      expl_q         <= '0;
      expl0_q        <= '0;
      prev_catch_q   <= '0;
      pred_catch_q   <= '0;
      alive_q        <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgLogistic) cfg_logistic_q <= cfg_data_i;
        if (cfg_index_i == CfgObserved) cfg_observed_q <= cfg_data_i;
      end

      // result register: load from the result stage, else drain when taken
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_ISSUE;
            if (first_year_i) begin
              step_q       <= ST_FIRST;
              alive_q      <= 1'b1;
              biomass_q    <= $signed({1'b0, capacity_i});
              pred_catch_q <= $signed({1'b0, catch_value_i});
              prev_catch_q <= catch_value_i;
            end else begin
              step_q <= cfg_logistic_q ? ST_AK : ST_ELIN;
            end
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (rsp.done) begin
            if (rsp.div_zero) alive_q <= 1'b0;
            case (step_q)
              ST_FIRST: begin
                expl_q  <= res[RateW-1:0];
                expl0_q <= res[RateW-1:0];
              end
              ST_ELOG: expl_q <= res[RateW-1:0];
              ST_ELIN: expl_q <= sat_rate(SumW'(expl_q) + SumW'(res));
              ST_GROW: biomass_q <= sat_bio(SumW'(biomass_q) + SumW'(res) - SumW'(sub_catch));
              ST_PC: begin
                pred_catch_q <= res;
                prev_catch_q <= catch_q;
                if (biomass_q <= 0 || expl_q < 0) alive_q <= 1'b0;
              end
              default: ;
            endcase
            step_q <= step_nxt;
            if (step_last) state_q <= last_q ? S_OUT : S_IDLE;
            else state_q <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // year operands, intermediates and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      catch_q <= catch_value_i;
      cap_q   <= capacity_i;
      r_q     <= growth_rate_i;
      x_q     <= effort_rate_i;
      a_q     <= effort_shape_i;
      last_q  <= last_year_i;
    end
    if (state_q == S_WAIT && rsp.done) begin
      case (step_q)
        ST_AK, ST_RB: tmp_q <= res;
        ST_RATIO:     term_q <= sat_rate(SumW'(res) - OneRate);
        ST_FACT:      term_q <= sat_rate(OneRate + SumW'(res));
        ST_BK:        frac_q <= sat_rate(OneRate - SumW'(res));
        default: ;
      endcase
    end
    if (state_q == S_OUT && out_free) begin
      out_bio_q  <= biomass_q;
      out_expl_q <= expl_q;
      out_surv_q <= alive_q;
    end
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign final_biomass_o      = out_bio_q;
  assign final_exploitation_o = out_expl_q;
  assign survived_o           = out_surv_q;

`ifndef SYNTHESIS
  // the unit only answers while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_WAIT))
    else $error("arith response outside wait state");

  // a result is only loaded for a year marked last
  a_out_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> last_q)
    else $error("result stage entered for a year not marked last");

  // a new result appears only from the result stage
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result raised without passing the result stage");
`endif

endmodule

FILE: hw/rtl/sppu_arith.sv
// Bit-serial fixed-point multiply / divide unit with saturation.
// Depends on sppu_pkg.
module sppu_arith (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sppu_pkg::arith_req_t            req_i,
  input  logic signed [sppu_pkg::BioW-1:0] opa_i,
  input  logic signed [sppu_pkg::BioW-1:0] opb_i,
  output sppu_pkg::arith_rsp_t            rsp_o,
  output logic signed [sppu_pkg::BioW-1:0] res_o
);
  import sppu_pkg::*;

  localparam int unsigned ProdW = 2 * BioW;
  localparam int unsigned DvdW  = BioW + Frac;
  localparam int unsigned QW    = RateW + 1;
  localparam int unsigned MagW  = ProdW - Frac;
  localparam int unsigned CntW  = $clog2(DvdW);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_FIN  = 4'b1000
  } ustate_e;

  ustate_e ustate_q, ustate_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic             neg_q, wide_q, is_div_q, dz_q, ovf_q;
  logic [BioW-1:0]  mcand_q;
  logic [ProdW-1:0] prod_q;
  logic [DvdW-1:0]  dvd_q;
  logic [BioW-1:0]  rem_q;
  logic [QW-1:0]    quot_q;

  logic [BioW-1:0]  mag_a, mag_b;
  logic [BioW:0]    mul_sum;
  logic [BioW:0]    rem_sh, rem_diff;
  logic             rem_ge;
  logic [MagW-1:0]  mag_val, mag_lim, mag_fin;
  logic [BioW-1:0]  mag_res;

  // operand magnitudes
  assign mag_a = opa_i[BioW-1] ? (~opa_i + BioW'(1)) : opa_i;
  assign mag_b = opb_i[BioW-1] ? (~opb_i + BioW'(1)) : opb_i;

  // one multiplier bit per cycle
  assign mul_sum = {1'b0, prod_q[ProdW-1:BioW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

  // one quotient bit per cycle
  assign rem_sh   = {rem_q, dvd_q[DvdW-1]};
  assign rem_ge   = rem_sh >= {1'b0, mcand_q};
  assign rem_diff = rem_sh - {1'b0, mcand_q};

  // control
  always_comb begin
    ustate_d = ustate_q;
    cnt_d    = cnt_q;
    unique case (ustate_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_DIV) begin
            ustate_d = (mag_b == '0) ? U_FIN : U_DIV;
            cnt_d    = CntW'(DvdW - 1);
          end else begin
            ustate_d = U_MUL;
            cnt_d    = CntW'(BioW - 1);
          end
        end
      end
      U_MUL, U_DIV: begin
        if (cnt_q == '0) ustate_d = U_FIN;
        else cnt_d = cnt_q - CntW'(1);
      end
      U_FIN:   ustate_d = U_IDLE;
      default: ustate_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ustate_q <= U_IDLE;
      cnt_q    <= '0;
    end else begin
      ustate_q <= ustate_d;
      cnt_q    <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ustate_q == U_IDLE && req_i.start) begin
      neg_q    <= opa_i[BioW-1] ^ opb_i[BioW-1];
      wide_q   <= req_i.wide;
      is_div_q <= (req_i.op == OP_DIV);
      dz_q     <= (req_i.op == OP_DIV) && (mag_b == '0);
      ovf_q    <= 1'b0;
      rem_q    <= '0;
      quot_q   <= '0;
      dvd_q    <= {mag_a, Frac'(0)};
      if (req_i.op == OP_DIV) begin
        mcand_q <= mag_b;
        prod_q  <= '0;
      end else begin
        mcand_q <= mag_a;
        prod_q  <= {BioW'(0), mag_b};
      end
    end else if (ustate_q == U_MUL) begin
      prod_q <= {mul_sum, prod_q[BioW-1:1]};
    end else if (ustate_q == U_DIV) begin
      rem_q  <= rem_ge ? rem_diff[BioW-1:0] : rem_sh[BioW-1:0];
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
      ovf_q  <= ovf_q | quot_q[QW-1];
      quot_q <= {quot_q[QW-2:0], rem_ge};
    end
  end

  // truncate, saturate and restore the sign
  assign mag_val = is_div_q ? MagW'(quot_q) : prod_q[ProdW-1:Frac];
  assign mag_lim = wide_q ? ((MagW'(1) << (BioW - 1)) - MagW'(!neg_q))
                          : ((MagW'(1) << (RateW - 1)) - MagW'(!neg_q));
  assign mag_fin = (ovf_q || (mag_val > mag_lim)) ? mag_lim : mag_val;
  assign mag_res = mag_fin[BioW-1:0];

  assign res_o = dz_q  ? '0 :
                 neg_q ? $signed(~mag_res + BioW'(1)) : $signed(mag_res);
  assign rsp_o.done     = (ustate_q == U_FIN);
  assign rsp_o.div_zero = (ustate_q == U_FIN) && dz_q;

endmodule
